// ----- rtl/flr_pkg.sv -----
// ----------------------------------------------------------------------------
// flr_pkg: shared types, codes and functions of the framed link receiver
// Framing states, result event codes, register indexes, the CRC-16/CCITT
// byte step and the structs passed between the receiver's modules.
// ----------------------------------------------------------------------------
package flr_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 11;
   localparam int unsigned CRC_W     = 16;
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;
   localparam int unsigned HDR_BYTES = 6;
   localparam int unsigned HCNT_W    = 3;

   // largest payload length a header may announce
   localparam logic [15:0] MTU_LIMIT = 16'd1024;

   localparam logic [BYTE_W-1:0] BROADCAST_ID = 8'hFF;
   localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h1021;
   localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STATION_ID  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CODE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_CODE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_CODE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_XOR  = 3'd5;

   // register reset values
   localparam logic [BYTE_W-1:0] RST_STATION_ID  = 8'h00;
   localparam logic [TICK_W-1:0] RST_TIMEOUT     = 16'd100;
   localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'h7E;
   localparam logic [BYTE_W-1:0] RST_END_CODE    = 8'h7F;
   localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'h7D;
   localparam logic [BYTE_W-1:0] RST_ESCAPE_XOR  = 8'h20;

   typedef enum logic [2:0] {
      ST_SYNC = 3'd0,
      ST_HDR  = 3'd1,
      ST_ESC  = 3'd2,
      ST_PLD  = 3'd3,
      ST_SKIP = 3'd4
   } state_type;

   typedef enum logic [2:0] {
      EV_BYPASS   = 3'd0,
      EV_PAYLOAD  = 3'd1,
      EV_GOOD     = 3'd2,
      EV_PLD_CRC  = 3'd3,
      EV_HDR_CRC  = 3'd4,
      EV_REJECT   = 3'd5,
      EV_TIMEOUT  = 3'd6
   } event_type;

   typedef enum logic {
      FUNC_BYTE = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   typedef struct packed {
      logic [BYTE_W-1:0] station_id;
      logic [TICK_W-1:0] timeout_ticks;
      logic [BYTE_W-1:0] start_code;
      logic [BYTE_W-1:0] end_code;
      logic [BYTE_W-1:0] escape_code;
      logic [BYTE_W-1:0] escape_xor;
   } cfg_type;

   typedef struct packed {
      event_type         event_res;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] dest_id;
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  payload_length;
      logic              frame_end;
   } result_type;

   // one byte of CRC-16/CCITT, msb first, no reflection
   function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/flr_req_if.sv -----
// ----------------------------------------------------------------------------
// flr_req_if: input item channel
// Carries one received byte or one time tick per item.
// ----------------------------------------------------------------------------
interface flr_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [flr_pkg::BYTE_W-1:0]     rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

// ----- rtl/flr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// flr_rsp_if: result item channel
// Carries one receiver event with its byte and header fields.
// ----------------------------------------------------------------------------
interface flr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     event_res;
   logic [flr_pkg::BYTE_W-1:0]     data_byte;
   logic [flr_pkg::BYTE_W-1:0]     dest_id;
   logic [flr_pkg::BYTE_W-1:0]     command;
   logic [flr_pkg::LEN_W-1:0]      payload_length;
   logic                           frame_end;

   modport source (output valid, output event_res, output data_byte, output dest_id,
                   output command, output payload_length, output frame_end,
                   input ready);
   modport sink   (input valid, input event_res, input data_byte, input dest_id,
                   input command, input payload_length, input frame_end,
                   output ready);
endinterface

// ----- rtl/flr_csr_if.sv -----
// ----------------------------------------------------------------------------
// flr_csr_if: register write channel
// Carries a register index and its write data.
// ----------------------------------------------------------------------------
interface flr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [flr_pkg::CSR_IDX_W-1:0]     index;
   logic [flr_pkg::CSR_DAT_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/framed_link_receiver.sv -----
// ----------------------------------------------------------------------------
// framed_link_receiver: byte-stuffed frame receiver with CRC-16/CCITT checks
// Top level: register file, frame parser and result register.
// ----------------------------------------------------------------------------
// Takes one item (a received byte or a time tick) per clock and gives at most
// one result per item, registered, in the cycle after the item is accepted. The
// parser's state, counters and CRC update in the same cycle the item is
// taken, so a new item is accepted every cycle as long as the result register
// is empty or its item is being taken by the sink. Register writes are always
// accepted and should only be issued while the receiver is idle. Outside a
// frame every byte other than the start code comes back as a bypass result;
// frames addressed to the local id or to 0xFF stream their payload bytes and
// end with a good or CRC-error verdict, other frames are skipped silently.
// ----------------------------------------------------------------------------
module framed_link_receiver #(
   parameter logic [15:0] MTU_LIMIT = flr_pkg::MTU_LIMIT
) (
   input  logic           clock,
   input  logic           reset,
   flr_req_if.sink        req_if,
   flr_rsp_if.source      rsp_if,
   flr_csr_if.sink        csr_if
);

   flr_pkg::cfg_type      cfg;
   flr_pkg::result_type   res;
   flr_pkg::result_type   out_res;
   logic                  res_valid;
   logic                  can_load;
   logic                  item_en;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = can_load;
   assign item_en      = req_if.valid && can_load;

   flr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .cfg      (cfg)
   );

   flr_parser #(
      .MTU_LIMIT (MTU_LIMIT)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .item_en   (item_en),
      .func      (req_if.func),
      .rx_byte   (req_if.rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   flr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (item_en && res_valid),
      .res       (res),
      .out_ready (rsp_if.ready),
      .out_valid (rsp_if.valid),
      .out_res   (out_res),
      .can_load  (can_load)
   );

   assign rsp_if.event_res      = out_res.event_res;
   assign rsp_if.data_byte      = out_res.data_byte;
   assign rsp_if.dest_id        = out_res.dest_id;
   assign rsp_if.command        = out_res.command;
   assign rsp_if.payload_length = out_res.payload_length;
   assign rsp_if.frame_end      = out_res.frame_end;

endmodule

// ----- rtl/flr_csr.sv -----
// ----------------------------------------------------------------------------
// flr_csr: configuration registers
// Holds station id, timeout and framing codes; writes to unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module flr_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [flr_pkg::CSR_IDX_W-1:0]   wr_index,
   input  logic [flr_pkg::CSR_DAT_W-1:0]   wr_data,
   output flr_pkg::cfg_type                cfg
);

   flr_pkg::cfg_type cfg_ff;
   flr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            flr_pkg::CSR_STATION_ID:  cfg_in.station_id    = wr_data[7:0];
            flr_pkg::CSR_TIMEOUT:     cfg_in.timeout_ticks = wr_data;
            flr_pkg::CSR_START_CODE:  cfg_in.start_code    = wr_data[7:0];
            flr_pkg::CSR_END_CODE:    cfg_in.end_code      = wr_data[7:0];
            flr_pkg::CSR_ESCAPE_CODE: cfg_in.escape_code   = wr_data[7:0];
            flr_pkg::CSR_ESCAPE_XOR:  cfg_in.escape_xor    = wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_id    <= flr_pkg::RST_STATION_ID;
         cfg_ff.timeout_ticks <= flr_pkg::RST_TIMEOUT;
         cfg_ff.start_code    <= flr_pkg::RST_START_CODE;
         cfg_ff.end_code      <= flr_pkg::RST_END_CODE;
         cfg_ff.escape_code   <= flr_pkg::RST_ESCAPE_CODE;
         cfg_ff.escape_xor    <= flr_pkg::RST_ESCAPE_XOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/flr_parser.sv -----
// ----------------------------------------------------------------------------
// flr_parser: frame parser
// Framing state machine, header store, byte counters, CRC accumulator and
// idle timer. Produces at most one result per accepted item.
// ----------------------------------------------------------------------------
module flr_parser #(
   parameter logic [15:0] MTU_LIMIT = flr_pkg::MTU_LIMIT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_en,
   input  logic                         func,
   input  logic [flr_pkg::BYTE_W-1:0]   rx_byte,
   input  flr_pkg::cfg_type             cfg,
   output logic                         res_valid,
   output flr_pkg::result_type          res
);

   flr_pkg::state_type              state_ff, state_in;
   logic [flr_pkg::BYTE_W-1:0]      hdr_ff [flr_pkg::HDR_BYTES];
   logic [flr_pkg::HCNT_W-1:0]      hcnt_ff, hcnt_in;
   logic [flr_pkg::LEN_W-1:0]       bcnt_ff, bcnt_in;
   logic [flr_pkg::LEN_W-1:0]       elen_ff, elen_in;
   logic [flr_pkg::CRC_W-1:0]       crc_ff, crc_in;
   logic [flr_pkg::BYTE_W-1:0]      crclo_ff, crclo_in;
   logic [flr_pkg::TICK_W-1:0]      idle_ff, idle_in;

   logic                            hdr_we;
   logic [flr_pkg::BYTE_W-1:0]      hdr_wdata;
   logic [flr_pkg::BYTE_W-1:0]      store_byte;
   logic                            do_store;
   logic [flr_pkg::CRC_W-1:0]       crc_step_out;
   logic [flr_pkg::BYTE_W-1:0]      crc_step_in;
   logic [flr_pkg::TICK_W-1:0]      idle_inc;
   logic [15:0]                     hdr_len;
   logic [flr_pkg::CRC_W-1:0]       hdr_crc;
   logic [flr_pkg::CRC_W-1:0]       pld_crc;

   assign hdr_len = {hdr_ff[3], hdr_ff[2]};
   assign hdr_crc = {hdr_ff[5], hdr_ff[4]};
   assign pld_crc = {rx_byte, crclo_ff};
   assign idle_inc = (idle_ff == flr_pkg::TICK_MAX) ? idle_ff : idle_ff + 1'b1;

   // one shared CRC byte step: header bytes or payload bytes, never both
   assign crc_step_in  = (state_ff == flr_pkg::ST_PLD) ? rx_byte : store_byte;
   assign crc_step_out = flr_pkg::crc16_step(crc_ff, crc_step_in);

   always_comb begin
      state_in   = state_ff;
      hcnt_in    = hcnt_ff;
      bcnt_in    = bcnt_ff;
      elen_in    = elen_ff;
      crc_in     = crc_ff;
      crclo_in   = crclo_ff;
      idle_in    = idle_ff;
      do_store   = 1'b0;
      store_byte = rx_byte;
      res_valid  = 1'b0;
      res        = '0;
      res.event_res = flr_pkg::EV_BYPASS;

      if (func == flr_pkg::FUNC_TICK) begin
         if (state_ff != flr_pkg::ST_SYNC) begin
            idle_in = idle_inc;
            if (idle_inc >= cfg.timeout_ticks) begin
               state_in      = flr_pkg::ST_SYNC;
               res_valid     = 1'b1;
               res.event_res = flr_pkg::EV_TIMEOUT;
            end
         end
      end else begin
         idle_in = '0;
         case (state_ff)
            flr_pkg::ST_SYNC: begin
               if (rx_byte == cfg.start_code) begin
                  state_in = flr_pkg::ST_HDR;
                  hcnt_in  = '0;
                  bcnt_in  = '0;
                  crc_in   = flr_pkg::CRC_INIT;
               end else begin
                  res_valid     = 1'b1;
                  res.event_res = flr_pkg::EV_BYPASS;
                  res.data_byte = rx_byte;
               end
            end
            flr_pkg::ST_HDR: begin
               if (rx_byte == cfg.start_code) begin
                  hcnt_in = '0;
                  bcnt_in = '0;
                  crc_in  = flr_pkg::CRC_INIT;
               end else if (rx_byte == cfg.escape_code) begin
                  state_in = flr_pkg::ST_ESC;
               end else if (rx_byte == cfg.end_code) begin
                  state_in = flr_pkg::ST_SYNC;
                  if (hcnt_ff != 3'(flr_pkg::HDR_BYTES)) begin
                     res_valid     = 1'b1;
                     res.event_res = flr_pkg::EV_REJECT;
                  end else if (hdr_crc != crc_ff) begin
                     res_valid     = 1'b1;
                     res.event_res = flr_pkg::EV_HDR_CRC;
                  end else if (hdr_len > MTU_LIMIT) begin
                     res_valid     = 1'b1;
                     res.event_res = flr_pkg::EV_REJECT;
                  end else begin
                     elen_in = hdr_len[flr_pkg::LEN_W-1:0];
                     bcnt_in = '0;
                     crc_in  = flr_pkg::CRC_INIT;
                     if (hdr_ff[0] == cfg.station_id || hdr_ff[0] == flr_pkg::BROADCAST_ID) begin
                        state_in = flr_pkg::ST_PLD;
                     end else begin
                        state_in = flr_pkg::ST_SKIP;
                     end
                  end
               end else begin
                  do_store = 1'b1;
               end
            end
            flr_pkg::ST_ESC: begin
               state_in = flr_pkg::ST_HDR;
               if (rx_byte == cfg.start_code) begin
                  hcnt_in = '0;
                  bcnt_in = '0;
                  crc_in  = flr_pkg::CRC_INIT;
               end else begin
                  do_store   = 1'b1;
                  store_byte = rx_byte ^ cfg.escape_xor;
               end
            end
            flr_pkg::ST_PLD: begin
               res.dest_id        = hdr_ff[0];
               res.command        = hdr_ff[1];
               res.payload_length = elen_ff;
               if (bcnt_ff < elen_ff) begin
                  crc_in        = crc_step_out;
                  bcnt_in       = bcnt_ff + 1'b1;
                  res_valid     = 1'b1;
                  res.event_res = flr_pkg::EV_PAYLOAD;
                  res.data_byte = rx_byte;
               end else if (bcnt_ff == elen_ff) begin
                  crclo_in = rx_byte;
                  bcnt_in  = bcnt_ff + 1'b1;
               end else begin
                  state_in      = flr_pkg::ST_SYNC;
                  res_valid     = 1'b1;
                  res.frame_end = 1'b1;
                  res.event_res = (pld_crc == crc_ff) ? flr_pkg::EV_GOOD
                                                      : flr_pkg::EV_PLD_CRC;
               end
            end
            flr_pkg::ST_SKIP: begin
               if ({1'b0, bcnt_ff} >= {1'b0, elen_ff} + 1'b1) begin
                  state_in = flr_pkg::ST_SYNC;
               end else begin
                  bcnt_in = bcnt_ff + 1'b1;
               end
            end
            default: begin
               state_in = flr_pkg::ST_SYNC;
            end
         endcase
      end

      // header bytes past the sixth are dropped; only the first four feed the CRC
      hdr_we    = 1'b0;
      hdr_wdata = store_byte;
      if (do_store && hcnt_ff < 3'(flr_pkg::HDR_BYTES)) begin
         hdr_we  = 1'b1;
         hcnt_in = hcnt_ff + 1'b1;
         if (hcnt_ff < 3'd4) begin
            crc_in = crc_step_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flr_pkg::ST_SYNC;
         hcnt_ff  <= '0;
         bcnt_ff  <= '0;
         elen_ff  <= '0;
         crc_ff   <= flr_pkg::CRC_INIT;
         crclo_ff <= '0;
         idle_ff  <= '0;
      end else if (item_en) begin
         state_ff <= state_in;
         hcnt_ff  <= hcnt_in;
         bcnt_ff  <= bcnt_in;
         elen_ff  <= elen_in;
         crc_ff   <= crc_in;
         crclo_ff <= crclo_in;
         idle_ff  <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < flr_pkg::HDR_BYTES; i++) begin
         if (item_en && hdr_we && hcnt_ff == 3'(i)) begin
            hdr_ff[i] <= hdr_wdata;
         end
      end
   end

endmodule

// ----- rtl/flr_out.sv -----
// ----------------------------------------------------------------------------
// flr_out: result register
// Holds one result item until the sink takes it; a new item may load in the
// same cycle the held one leaves.
// ----------------------------------------------------------------------------
module flr_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  flr_pkg::result_type   res,
   input  logic                  out_ready,
   output logic                  out_valid,
   output flr_pkg::result_type   out_res,
   output logic                  can_load
);

   logic                  valid_ff, valid_in;
   flr_pkg::result_type   res_ff;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

// ----- test/framed_link_receiver_test.sv -----
// ----------------------------------------------------------------------------
// framed_link_receiver_test: self-checking bench for the framed link receiver
// Drives byte and tick items through the request channel and predicts every
// event with an in-bench deframer model. Directed frames cover bypass, good
// and broken frames, header faults, code priority and idle timeouts. Random
// frame streams then run under four register settings and pacing mixes.
// ----------------------------------------------------------------------------
module framed_link_receiver_test;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   logic clock = 1'b0;
   logic reset;

   flr_req_if req_if ();
   flr_rsp_if rsp_if ();
   flr_csr_if csr_if ();

   framed_link_receiver i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // deframer model state
   flr_pkg::cfg_type    regs;
   flr_pkg::state_type  parse_state;
   logic [7:0]          hdr_bytes [flr_pkg::HDR_BYTES];
   logic [2:0]          hdr_count;
   logic [11:0]         pld_count;
   logic [10:0]         pld_len;
   logic [15:0]         crc_run;
   logic [7:0]          crc_first;
   logic [15:0]         idle_run;

   flr_pkg::result_type pending_events [$];
   logic [7:0]          wire_q [$];

   int unsigned     errors = 0;
   int unsigned     cycles = 0;
   int unsigned     items_sent = 0;
   int unsigned     seen_events [8] = '{default: 0};
   int unsigned     idle_pct = 0;
   int unsigned     stall_pct = 0;

   function automatic logic [15:0] ccitt_byte(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {b, 8'h00};
      repeat (8) c = c[15] ? ((c << 1) ^ flr_pkg::CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic void push_event(flr_pkg::event_type ev, logic [7:0] d, bit with_hdr);
      flr_pkg::result_type r;
      r.event_res      = ev;
      r.data_byte      = d;
      r.dest_id        = with_hdr ? hdr_bytes[0] : 8'h00;
      r.command        = with_hdr ? hdr_bytes[1] : 8'h00;
      r.payload_length = with_hdr ? pld_len : 11'd0;
      r.frame_end      = (ev == flr_pkg::EV_GOOD || ev == flr_pkg::EV_PLD_CRC);
      pending_events.push_back(r);
   endfunction

   function automatic void open_header();
      parse_state = flr_pkg::ST_HDR;
      hdr_count   = '0;
      pld_count   = '0;
      crc_run     = flr_pkg::CRC_INIT;
   endfunction

   function automatic void keep_header_byte(logic [7:0] b);
      if (hdr_count < flr_pkg::HDR_BYTES) begin
         if (hdr_count < 4) crc_run = ccitt_byte(crc_run, b);
         hdr_bytes[hdr_count] = b;
         hdr_count++;
      end
   endfunction

   function automatic void deframe_item(flr_pkg::func_type f, logic [7:0] b);
      logic [15:0] rcv;
      logic [15:0] len;
      if (f == flr_pkg::FUNC_TICK) begin
         if (parse_state == flr_pkg::ST_SYNC) return;
         if (idle_run != flr_pkg::TICK_MAX) idle_run++;
         if (idle_run >= regs.timeout_ticks) begin
            parse_state = flr_pkg::ST_SYNC;
            push_event(flr_pkg::EV_TIMEOUT, 8'h00, 1'b0);
         end
         return;
      end
      idle_run = '0;
      case (parse_state)
         flr_pkg::ST_SYNC: begin
            if (b == regs.start_code) open_header();
            else push_event(flr_pkg::EV_BYPASS, b, 1'b0);
         end
         flr_pkg::ST_HDR: begin
            if (b == regs.start_code) begin
               open_header();
            end else if (b == regs.escape_code) begin
               parse_state = flr_pkg::ST_ESC;
            end else if (b == regs.end_code) begin
               rcv = {hdr_bytes[5], hdr_bytes[4]};
               len = {hdr_bytes[3], hdr_bytes[2]};
               if (hdr_count != flr_pkg::HDR_BYTES) begin
                  parse_state = flr_pkg::ST_SYNC;
                  push_event(flr_pkg::EV_REJECT, 8'h00, 1'b0);
               end else if (rcv != crc_run) begin
                  parse_state = flr_pkg::ST_SYNC;
                  push_event(flr_pkg::EV_HDR_CRC, 8'h00, 1'b0);
               end else if (len > flr_pkg::MTU_LIMIT) begin
                  parse_state = flr_pkg::ST_SYNC;
                  push_event(flr_pkg::EV_REJECT, 8'h00, 1'b0);
               end else begin
                  pld_len   = len[10:0];
                  pld_count = '0;
                  crc_run   = flr_pkg::CRC_INIT;
                  if (hdr_bytes[0] == regs.station_id || hdr_bytes[0] == flr_pkg::BROADCAST_ID)
                     parse_state = flr_pkg::ST_PLD;
                  else
                     parse_state = flr_pkg::ST_SKIP;
               end
            end else begin
               keep_header_byte(b);
            end
         end
         flr_pkg::ST_ESC: begin
            if (b == regs.start_code) begin
               open_header();
            end else begin
               keep_header_byte(b ^ regs.escape_xor);
               parse_state = flr_pkg::ST_HDR;
            end
         end
         flr_pkg::ST_PLD: begin
            if (pld_count < pld_len) begin
               crc_run = ccitt_byte(crc_run, b);
               pld_count++;
               push_event(flr_pkg::EV_PAYLOAD, b, 1'b1);
            end else if (pld_count == pld_len) begin
               crc_first = b;
               pld_count++;
            end else begin
               parse_state = flr_pkg::ST_SYNC;
               push_event(({b, crc_first} == crc_run) ? flr_pkg::EV_GOOD
                                                      : flr_pkg::EV_PLD_CRC,
                          8'h00, 1'b1);
            end
         end
         flr_pkg::ST_SKIP: begin
            if (pld_count >= pld_len + 12'd1) parse_state = flr_pkg::ST_SYNC;
            else pld_count++;
         end
         default: parse_state = flr_pkg::ST_SYNC;
      endcase
   endfunction

   // header bytes equal to any framing code go out escaped
   function automatic void put_hdr_byte(logic [7:0] b);
      if (b == regs.start_code || b == regs.escape_code || b == regs.end_code) begin
         wire_q.push_back(regs.escape_code);
         wire_q.push_back(b ^ regs.escape_xor);
      end else begin
         wire_q.push_back(b);
      end
   endfunction

   // hdr_adj < 0 drops header bytes, > 0 appends extra ones
   function automatic void build_frame(logic [7:0] tgt, logic [7:0] cmd, logic [15:0] len,
                                       logic [15:0] hdr_err, logic [15:0] pld_err,
                                       int hdr_adj);
      logic [7:0]  h [6];
      logic [15:0] c;
      logic [7:0]  d;
      int          n;
      h = '{tgt, cmd, len[7:0], len[15:8], 8'h00, 8'h00};
      c = flr_pkg::CRC_INIT;
      for (int i = 0; i < 4; i++) c = ccitt_byte(c, h[i]);
      c = c ^ hdr_err;
      h[4] = c[7:0];
      h[5] = c[15:8];
      n = 6 + hdr_adj;
      wire_q.delete();
      wire_q.push_back(regs.start_code);
      for (int i = 0; i < n; i++) put_hdr_byte((i < 6) ? h[i] : 8'($urandom));
      wire_q.push_back(regs.end_code);
      if (hdr_err == 0 && hdr_adj >= 0 && len <= flr_pkg::MTU_LIMIT) begin
         c = flr_pkg::CRC_INIT;
         for (int i = 0; i < int'(len); i++) begin
            d = ($urandom_range(7) == 0) ? regs.start_code : 8'($urandom);
            c = ccitt_byte(c, d);
            wire_q.push_back(d);
         end
         c = c ^ pld_err;
         wire_q.push_back(c[7:0]);
         wire_q.push_back(c[15:8]);
      end
   endfunction

   task automatic send_item(flr_pkg::func_type f, logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.func    <= f;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      if (!(f == flr_pkg::FUNC_TICK && parse_state == flr_pkg::ST_SYNC)) items_sent++;
      deframe_item(f, b);
      @(negedge clock);
   endtask

   task automatic send_wire(int unsigned count, int unsigned tick_pct);
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(99) < tick_pct) send_item(flr_pkg::FUNC_TICK, 8'($urandom));
         send_item(flr_pkg::FUNC_BYTE, wire_q[i]);
      end
   endtask

   task automatic send_frame(logic [7:0] tgt, logic [7:0] cmd, logic [15:0] len,
                             logic [15:0] hdr_err, logic [15:0] pld_err, int hdr_adj,
                             int unsigned tick_pct);
      build_frame(tgt, cmd, len, hdr_err, pld_err, hdr_adj);
      send_wire(wire_q.size(), tick_pct);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      // items without a result may still be in flight
      repeat (4) @(negedge clock);
   endtask

   task automatic load_config(logic [7:0] lid, logic [15:0] tmo, logic [7:0] sc,
                              logic [7:0] ec, logic [7:0] xc, logic [7:0] xm);
      logic [flr_pkg::CSR_IDX_W-1:0] idx [6];
      logic [flr_pkg::CSR_DAT_W-1:0] val [6];
      idx = '{flr_pkg::CSR_STATION_ID, flr_pkg::CSR_TIMEOUT, flr_pkg::CSR_START_CODE,
              flr_pkg::CSR_END_CODE, flr_pkg::CSR_ESCAPE_CODE, flr_pkg::CSR_ESCAPE_XOR};
      val = '{16'(lid), tmo, 16'(sc), 16'(ec), 16'(xc), 16'(xm)};
      wait_drained();
      for (int i = 0; i < 6; i++) begin
         csr_if.valid <= 1'b1;
         csr_if.index <= idx[i];
         csr_if.data  <= val[i];
         do @(posedge clock); while (!csr_if.ready);
         @(negedge clock);
      end
      csr_if.valid       <= 1'b0;
      regs.station_id    = lid;
      regs.timeout_ticks = tmo;
      regs.start_code    = sc;
      regs.end_code      = ec;
      regs.escape_code   = xc;
      regs.escape_xor    = xm;
   endtask

   task automatic test_bypass();
      send_item(flr_pkg::FUNC_BYTE, 8'h00);
      send_item(flr_pkg::FUNC_BYTE, 8'hFF);
      send_item(flr_pkg::FUNC_BYTE, 8'h5A);
      send_item(flr_pkg::FUNC_TICK, 8'hA5);  // ignored while waiting for sync
   endtask

   task automatic test_frames();
      send_frame(flr_pkg::BROADCAST_ID, flr_pkg::RST_START_CODE, 16'd3, '0, '0, 0, 0);
      send_frame(flr_pkg::RST_STATION_ID, flr_pkg::RST_ESCAPE_CODE, 16'd0, '0, '0, 0, 0);
      send_frame(8'h42, flr_pkg::RST_END_CODE, 16'd2, '0, '0, 0, 0);
      send_frame(flr_pkg::BROADCAST_ID, 8'h10, 16'd1, '0, 16'h0001, 0, 0);
   endtask

   task automatic test_header_faults();
      send_frame(flr_pkg::BROADCAST_ID, 8'h20, 16'd1, 16'h8000, '0, 0, 0);
      send_frame(flr_pkg::BROADCAST_ID, 8'h21, 16'd1, '0, '0, -1, 0);
      send_frame(flr_pkg::BROADCAST_ID, 8'h22, 16'd1, '0, '0, -6, 0);
      send_frame(flr_pkg::RST_STATION_ID, 8'h23, 16'd1, '0, '0, 2, 0);
      send_frame(flr_pkg::BROADCAST_ID, 8'h24, flr_pkg::MTU_LIMIT + 16'd1, '0, '0, 0, 0);
      send_frame(flr_pkg::BROADCAST_ID, 8'h25, 16'hFFFF, '0, '0, 0, 0);
      // restart inside the header, then right after an escape
      build_frame(flr_pkg::BROADCAST_ID, 8'h26, 16'd1, '0, '0, 0);
      send_wire(4, 0);
      wire_q = '{flr_pkg::RST_START_CODE, 8'h01, flr_pkg::RST_ESCAPE_CODE};
      send_wire(3, 0);
      send_frame(flr_pkg::BROADCAST_ID, 8'h27, 16'd2, '0, '0, 0, 0);
   endtask

   task automatic test_code_priority();
      // all three codes equal: start wins, frame never closes
      load_config(flr_pkg::RST_STATION_ID, 16'd2, 8'h55, 8'h55, 8'h55,
                  flr_pkg::RST_ESCAPE_XOR);
      wire_q = '{8'h55, 8'h01, 8'h02, 8'h55, 8'h03};
      send_wire(5, 0);
      repeat (2) send_item(flr_pkg::FUNC_TICK, 8'h00);
      // escape equal to end: escape wins
      load_config(flr_pkg::RST_STATION_ID, 16'd2, flr_pkg::RST_START_CODE, 8'h40, 8'h40,
                  flr_pkg::RST_ESCAPE_XOR);
      send_frame(flr_pkg::RST_STATION_ID, 8'h40, 16'd0, '0, '0, 0, 0);
      repeat (2) send_item(flr_pkg::FUNC_TICK, 8'hFF);
   endtask

   task automatic test_timeouts();
      load_config(flr_pkg::RST_STATION_ID, 16'd0, flr_pkg::RST_START_CODE,
                  flr_pkg::RST_END_CODE, flr_pkg::RST_ESCAPE_CODE, flr_pkg::RST_ESCAPE_XOR);
      send_item(flr_pkg::FUNC_BYTE, flr_pkg::RST_START_CODE);
      send_item(flr_pkg::FUNC_TICK, 8'h5A);
      load_config(flr_pkg::RST_STATION_ID, 16'd1, flr_pkg::RST_START_CODE,
                  flr_pkg::RST_END_CODE, flr_pkg::RST_ESCAPE_CODE, flr_pkg::RST_ESCAPE_XOR);
      build_frame(flr_pkg::BROADCAST_ID, 8'h40, 16'd4, '0, '0, 0);
      send_wire(wire_q.size() - 3, 0);
      send_item(flr_pkg::FUNC_TICK, 8'h00);
      // largest allowed length is taken; the stream is cut after a few bytes
      build_frame(flr_pkg::BROADCAST_ID, 8'hFF, flr_pkg::MTU_LIMIT, '0, '0, 0);
      send_wire(wire_q.size() - 1020, 0);
      send_item(flr_pkg::FUNC_TICK, 8'h00);
      load_config(flr_pkg::RST_STATION_ID, 16'd20, flr_pkg::RST_START_CODE,
                  flr_pkg::RST_END_CODE, flr_pkg::RST_ESCAPE_CODE, flr_pkg::RST_ESCAPE_XOR);
      send_item(flr_pkg::FUNC_BYTE, flr_pkg::RST_START_CODE);
      repeat (20) send_item(flr_pkg::FUNC_TICK, 8'($urandom));
   endtask

   task automatic run_random(int unsigned quota, int unsigned tick_pct);
      int unsigned start_items;
      int unsigned pause_at;
      int unsigned pick;
      int          shrink;
      int          hdr_adj;
      bit          paused;
      logic [7:0]  tgt;
      logic [15:0] len;
      logic [15:0] hdr_err;
      logic [15:0] pld_err;
      start_items = items_sent;
      pause_at    = $urandom_range(quota / 4, 3 * quota / 4);
      paused      = 1'b0;
      while (items_sent - start_items < quota) begin
         if (!paused && items_sent - start_items >= pause_at) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         case ($urandom_range(2))
            0: tgt = regs.station_id;
            1: tgt = flr_pkg::BROADCAST_ID;
            default: tgt = 8'($urandom);
         endcase
         len = ($urandom_range(15) == 0) ? 16'($urandom_range(9, 40))
                                         : 16'($urandom_range(8));
         hdr_err = '0;
         pld_err = '0;
         hdr_adj = 0;
         if (pick >= 86) begin
            if (pick < 92) begin
               // line noise outside frames
               wire_q.delete();
               repeat ($urandom_range(1, 4)) wire_q.push_back(8'($urandom));
               send_wire(wire_q.size(), tick_pct);
            end else begin
               // frame cut short, then left to time out
               build_frame(tgt, 8'($urandom), len, '0, '0, 0);
               send_wire($urandom_range(1, wire_q.size() - 1), tick_pct);
               if (regs.timeout_ticks <= 16)
                  repeat ((regs.timeout_ticks == 0) ? 1 : regs.timeout_ticks)
                     send_item(flr_pkg::FUNC_TICK, 8'($urandom));
            end
         end else begin
            if (pick >= 82) begin
               len = 16'($urandom_range(flr_pkg::MTU_LIMIT + 1, flr_pkg::TICK_MAX));
            end else if (pick >= 78) begin
               hdr_adj = $urandom_range(1, 3);
            end else if (pick >= 74) begin
               shrink  = $urandom_range(1, 6);
               hdr_adj = -shrink;
            end else if (pick >= 68) begin
               hdr_err = 16'($urandom_range(1, flr_pkg::TICK_MAX));
            end else if (pick >= 60) begin
               pld_err = 16'($urandom_range(1, flr_pkg::TICK_MAX));
            end
            send_frame(tgt, 8'($urandom), len, hdr_err, pld_err, hdr_adj, tick_pct);
         end
      end
   endtask

   task automatic test_random();
      logic [7:0] esc;
      idle_pct  = 0;
      stall_pct = 0;
      load_config(8'h00, 16'd1, flr_pkg::RST_START_CODE, flr_pkg::RST_END_CODE,
                  flr_pkg::RST_ESCAPE_CODE, flr_pkg::RST_ESCAPE_XOR);
      run_random(80, 3);
      idle_pct  = 85;
      stall_pct = 0;
      load_config(8'hFF, 16'd4, 8'h00, 8'hFF, 8'h01, 8'hFF);
      run_random(80, 3);
      idle_pct  = 0;
      stall_pct = 85;
      load_config(8'($urandom), 16'd6, 8'hFF, 8'h00, 8'h80, 8'h00);
      run_random(80, 3);
      idle_pct  = 10;
      stall_pct = 10;
      esc = 8'($urandom);
      load_config(8'($urandom), 16'($urandom_range(2, 12)), 8'($urandom),
                  ($urandom_range(3) == 0) ? esc : 8'($urandom), esc, 8'($urandom));
      run_random(80, 3);
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      flr_pkg::result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event %0d, expected none, actual data %0h",
                     $time, rsp_if.event_res, rsp_if.data_byte);
            errors++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_res", 16'(want.event_res), 16'(rsp_if.event_res));
            check_field("data_byte", 16'(want.data_byte), 16'(rsp_if.data_byte));
            check_field("dest_id", 16'(want.dest_id), 16'(rsp_if.dest_id));
            check_field("command", 16'(want.command), 16'(rsp_if.command));
            check_field("payload_length", 16'(want.payload_length),
                        16'(rsp_if.payload_length));
            check_field("frame_end", 16'(want.frame_end), 16'(rsp_if.frame_end));
         end
         seen_events[rsp_if.event_res]++;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d events still pending",
                  $time, cycles, pending_events.size());
         $display("FAIL framed_link_receiver");
         $finish;
      end
   end

   initial begin
      req_if.valid   = 1'b0;
      req_if.func    = flr_pkg::FUNC_BYTE;
      req_if.rx_byte = '0;
      csr_if.valid   = 1'b0;
      csr_if.index   = flr_pkg::CSR_STATION_ID;
      csr_if.data    = '0;
      reset          = 1'b1;

      regs.station_id    = flr_pkg::RST_STATION_ID;
      regs.timeout_ticks = flr_pkg::RST_TIMEOUT;
      regs.start_code    = flr_pkg::RST_START_CODE;
      regs.end_code      = flr_pkg::RST_END_CODE;
      regs.escape_code   = flr_pkg::RST_ESCAPE_CODE;
      regs.escape_xor    = flr_pkg::RST_ESCAPE_XOR;
      parse_state = flr_pkg::ST_SYNC;
      hdr_bytes   = '{default: 8'h00};
      hdr_count   = '0;
      pld_count   = '0;
      pld_len     = '0;
      crc_run     = flr_pkg::CRC_INIT;
      crc_first   = '0;
      idle_run    = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bypass();
      test_frames();
      test_header_faults();
      test_code_priority();
      test_timeouts();
      test_random();

      wait_drained();
      repeat (10) @(negedge clock);

      $display("Ran %0d items through directed frames and four pacing mixes: %0d bypass, %0d payload",
               items_sent, seen_events[flr_pkg::EV_BYPASS], seen_events[flr_pkg::EV_PAYLOAD]);
      $display("Verdicts: %0d good, %0d payload CRC, %0d header CRC, %0d rejected, %0d timeouts",
               seen_events[flr_pkg::EV_GOOD], seen_events[flr_pkg::EV_PLD_CRC],
               seen_events[flr_pkg::EV_HDR_CRC], seen_events[flr_pkg::EV_REJECT],
               seen_events[flr_pkg::EV_TIMEOUT]);
      if (errors == 0) begin
         $display("PASS framed_link_receiver");
      end else begin
         $display("FAIL framed_link_receiver");
      end
      $finish;
   end

endmodule
